// ===== src/qvr_pkg.sv =====
// Shared widths and payload types of the quaternion vector rotation pipeline.
`timescale 1ns / 1ps
`default_nettype none
package qvr_pkg;

  // The rotation and the vector are block scaled to this many magnitude bits.
  localparam int MANT_BITS = 19;
  localparam int MW        = MANT_BITS + 1;
  localparam int PROD_BITS = 2 * MW;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int TERM_BITS = SUM_BITS + MW;
  localparam int R_BITS    = 64;
  // The rotated vector is block scaled to this many magnitude bits.
  localparam int LEN_BITS  = 30;
  localparam int SQ_BITS   = 2 * LEN_BITS + 2;
  localparam int ROOT_BITS = LEN_BITS + 1;

  typedef logic signed [MW-1:0] mant_t;

  typedef struct packed {
    logic zq;
    logic zv;
    logic zr;
  } flags_t;

  typedef struct packed {
    mant_t  qx;
    mant_t  qy;
    mant_t  qz;
    mant_t  qw;
    mant_t  vx;
    mant_t  vy;
    mant_t  vz;
    flags_t flags;
  } scaled_t;

  typedef struct packed {
    logic [2:0][R_BITS-1:0] r;
    flags_t                 flags;
  } rot_t;

  typedef struct packed {
    logic [2:0][LEN_BITS-1:0] mag;
    logic [2:0]               neg;
    flags_t                   flags;
  } dir_t;

  typedef struct packed {
    dir_t               dir;
    logic [SQ_BITS-1:0] sum;
  } norm_t;

  typedef struct packed {
    dir_t                 dir;
    logic [ROOT_BITS-1:0] len;
  } unit_t;

endpackage
`default_nettype wire

// ===== src/qvr_in_if.sv =====
// Input channel of the rotation block: a vector quaternion and a rotation quaternion.
`timescale 1ns / 1ps
`default_nettype none
interface qvr_in_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] vec_x;
  logic signed [WORD_BITS-1:0] vec_y;
  logic signed [WORD_BITS-1:0] vec_z;
  logic signed [WORD_BITS-1:0] vec_w;
  logic signed [WORD_BITS-1:0] rot_qx;
  logic signed [WORD_BITS-1:0] rot_qy;
  logic signed [WORD_BITS-1:0] rot_qz;
  logic signed [WORD_BITS-1:0] rot_qw;

  modport source (output valid, vec_x, vec_y, vec_z, vec_w, rot_qx, rot_qy, rot_qz, rot_qw,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, vec_w, rot_qx, rot_qy, rot_qz, rot_qw,
                output ready);
endinterface
`default_nettype wire

// ===== src/qvr_out_if.sv =====
// Output channel of the rotation block: the rotated unit vector and its flags.
`timescale 1ns / 1ps
`default_nettype none
interface qvr_out_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] out_x;
  logic signed [WORD_BITS-1:0] out_y;
  logic signed [WORD_BITS-1:0] out_z;
  logic                        zero_quat;
  logic                        zero_result;

  modport source (output valid, out_x, out_y, out_z, zero_quat, zero_result, input ready);
  modport sink (input valid, out_x, out_y, out_z, zero_quat, zero_result, output ready);
endinterface
`default_nettype wire

// ===== src/qvr_pipe_ctrl.sv =====
// Valid tracking and per-stage load enables of a stallable pipeline segment.
`timescale 1ns / 1ps
`default_nettype none
module qvr_pipe_ctrl #(
  parameter int STAGES = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAGES-1:0] adv
);

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] vld_next;
  logic [STAGES-1:0] feed;

  // A stage loads when it is empty or when the stage after it moves on.
  for (genvar i = 0; i < STAGES; i++) begin : g_adv
    if (i == STAGES - 1) begin : g_last
      assign adv[i] = !vld[i] || out_ready;
    end else begin : g_mid
      assign adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign feed     = {vld[STAGES-2:0], in_valid};
  assign vld_next = (adv & feed) | (~adv & vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[STAGES-1];

endmodule
`default_nettype wire

// ===== src/qvr_prenorm.sv =====
// Block scaling of the rotation quaternion and of the vector to 19 magnitude bits.
`timescale 1ns / 1ps
`default_nettype none
module qvr_prenorm import qvr_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [WORD_BITS-1:0] vec_x,
  input  logic signed [WORD_BITS-1:0] vec_y,
  input  logic signed [WORD_BITS-1:0] vec_z,
  input  logic signed [WORD_BITS-1:0] rot_qx,
  input  logic signed [WORD_BITS-1:0] rot_qy,
  input  logic signed [WORD_BITS-1:0] rot_qz,
  input  logic signed [WORD_BITS-1:0] rot_qw,
  output logic                        out_valid,
  input  logic                        out_ready,
  output scaled_t                     out_data
);

  localparam int STAGES   = 3;
  localparam int EXT_BITS = WORD_BITS + MANT_BITS;
  localparam int BL_BITS  = $clog2(EXT_BITS + 1);

  typedef logic [WORD_BITS-1:0] mag_t;

  function automatic mag_t magnitude(input logic signed [WORD_BITS-1:0] x);
    return x[WORD_BITS-1] ? mag_t'(-x) : mag_t'(x);
  endfunction

  function automatic logic [BL_BITS-1:0] bit_length(input mag_t m);
    logic [BL_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (m[i]) begin
        n = BL_BITS'(i + 1);
      end
    end
    return n;
  endfunction

  // Left shifts are exact; right shifts truncate the magnitude toward zero.
  function automatic mant_t scale(input mag_t m, input logic neg, input logic [BL_BITS-1:0] bl);
    logic [EXT_BITS-1:0]  ext;
    logic [EXT_BITS-1:0]  sh;
    logic [MANT_BITS-1:0] res;
    ext = EXT_BITS'(m);
    if (bl > BL_BITS'(MANT_BITS)) begin
      sh = ext >> (bl - BL_BITS'(MANT_BITS));
    end else begin
      sh = ext << (BL_BITS'(MANT_BITS) - bl);
    end
    res = sh[MANT_BITS-1:0];
    return neg ? -mant_t'({1'b0, res}) : mant_t'({1'b0, res});
  endfunction

  logic [STAGES-1:0] adv;

  qvr_pipe_ctrl #(.STAGES(STAGES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .adv      (adv)
  );

  // Element order: qx, qy, qz, qw, vx, vy, vz.
  mag_t               m1 [7];
  logic [6:0]         n1;
  mag_t               or_q1;
  mag_t               or_v1;
  mag_t               m2 [7];
  logic [6:0]         n2;
  logic [BL_BITS-1:0] bl_q2;
  logic [BL_BITS-1:0] bl_v2;
  flags_t             f2;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      m1[0] <= magnitude(rot_qx);
      m1[1] <= magnitude(rot_qy);
      m1[2] <= magnitude(rot_qz);
      m1[3] <= magnitude(rot_qw);
      m1[4] <= magnitude(vec_x);
      m1[5] <= magnitude(vec_y);
      m1[6] <= magnitude(vec_z);
      n1    <= {vec_z[WORD_BITS-1], vec_y[WORD_BITS-1], vec_x[WORD_BITS-1],
                rot_qw[WORD_BITS-1], rot_qz[WORD_BITS-1], rot_qy[WORD_BITS-1],
                rot_qx[WORD_BITS-1]};
      or_q1 <= magnitude(rot_qx) | magnitude(rot_qy) | magnitude(rot_qz) | magnitude(rot_qw);
      or_v1 <= magnitude(vec_x) | magnitude(vec_y) | magnitude(vec_z);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 7; i++) begin
        m2[i] <= m1[i];
      end
      n2       <= n1;
      bl_q2    <= bit_length(or_q1);
      bl_v2    <= bit_length(or_v1);
      f2.zq    <= (or_q1 == '0);
      f2.zv    <= (or_v1 == '0);
      f2.zr    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      out_data.qx    <= scale(m2[0], n2[0], bl_q2);
      out_data.qy    <= scale(m2[1], n2[1], bl_q2);
      out_data.qz    <= scale(m2[2], n2[2], bl_q2);
      out_data.qw    <= scale(m2[3], n2[3], bl_q2);
      out_data.vx    <= scale(m2[4], n2[4], bl_v2);
      out_data.vy    <= scale(m2[5], n2[5], bl_v2);
      out_data.vz    <= scale(m2[6], n2[6], bl_v2);
      out_data.flags <= f2;
    end
  end

endmodule
`default_nettype wire

// ===== src/qvr_rotate.sv =====
// Exact rotation r = (w*w - u.u) v + 2 (u.v) u + 2 w (u x v) in four stages.
`timescale 1ns / 1ps
`default_nettype none
module qvr_rotate import qvr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  scaled_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output rot_t    out_data
);

  localparam int STAGES = 4;

  logic [STAGES-1:0] adv;

  qvr_pipe_ctrl #(.STAGES(STAGES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .adv      (adv)
  );

  scaled_t                      d1;
  logic signed [PROD_BITS-1:0]  p_ww, p_xx, p_yy, p_zz, p_dx, p_dy, p_dz;
  logic signed [PROD_BITS-1:0]  p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  scaled_t                      d2;
  logic signed [SUM_BITS-1:0]   s2, dot2, cx2, cy2, cz2;
  flags_t                       f3;
  logic signed [TERM_BITS-1:0]  sv_x, sv_y, sv_z, du_x, du_y, du_z, wc_x, wc_y, wc_z;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d1   <= in_data;
      p_ww <= in_data.qw * in_data.qw;
      p_xx <= in_data.qx * in_data.qx;
      p_yy <= in_data.qy * in_data.qy;
      p_zz <= in_data.qz * in_data.qz;
      p_dx <= in_data.qx * in_data.vx;
      p_dy <= in_data.qy * in_data.vy;
      p_dz <= in_data.qz * in_data.vz;
      p_yz <= in_data.qy * in_data.vz;
      p_zy <= in_data.qz * in_data.vy;
      p_zx <= in_data.qz * in_data.vx;
      p_xz <= in_data.qx * in_data.vz;
      p_xy <= in_data.qx * in_data.vy;
      p_yx <= in_data.qy * in_data.vx;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      d2   <= d1;
      s2   <= SUM_BITS'(p_ww) - SUM_BITS'(p_xx) - SUM_BITS'(p_yy) - SUM_BITS'(p_zz);
      dot2 <= SUM_BITS'(p_dx) + SUM_BITS'(p_dy) + SUM_BITS'(p_dz);
      cx2  <= SUM_BITS'(p_yz) - SUM_BITS'(p_zy);
      cy2  <= SUM_BITS'(p_zx) - SUM_BITS'(p_xz);
      cz2  <= SUM_BITS'(p_xy) - SUM_BITS'(p_yx);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      f3   <= d2.flags;
      sv_x <= s2 * d2.vx;
      sv_y <= s2 * d2.vy;
      sv_z <= s2 * d2.vz;
      du_x <= dot2 * d2.qx;
      du_y <= dot2 * d2.qy;
      du_z <= dot2 * d2.qz;
      wc_x <= cx2 * d2.qw;
      wc_y <= cy2 * d2.qw;
      wc_z <= cz2 * d2.qw;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      out_data.flags <= f3;
      out_data.r[0]  <= R_BITS'(sv_x) + (R_BITS'(du_x) <<< 1) + (R_BITS'(wc_x) <<< 1);
      out_data.r[1]  <= R_BITS'(sv_y) + (R_BITS'(du_y) <<< 1) + (R_BITS'(wc_y) <<< 1);
      out_data.r[2]  <= R_BITS'(sv_z) + (R_BITS'(du_z) <<< 1) + (R_BITS'(wc_z) <<< 1);
    end
  end

endmodule
`default_nettype wire

// ===== src/qvr_renorm.sv =====
// Block scaling of the rotated vector to 30 magnitude bits and its squared length.
`timescale 1ns / 1ps
`default_nettype none
module qvr_renorm import qvr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  rot_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output norm_t out_data
);

  localparam int STAGES   = 5;
  localparam int EXT_BITS = R_BITS + LEN_BITS;
  localparam int BL_BITS  = $clog2(R_BITS + 1);

  logic [STAGES-1:0] adv;

  qvr_pipe_ctrl #(.STAGES(STAGES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .adv      (adv)
  );

  function automatic logic [R_BITS-1:0] magnitude(input logic [R_BITS-1:0] x);
    return x[R_BITS-1] ? -x : x;
  endfunction

  function automatic logic [BL_BITS-1:0] bit_length(input logic [R_BITS-1:0] m);
    logic [BL_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < R_BITS; i++) begin
      if (m[i]) begin
        n = BL_BITS'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [LEN_BITS-1:0] scale(input logic [R_BITS-1:0] m,
                                                input logic [BL_BITS-1:0] bl);
    logic [EXT_BITS-1:0] ext;
    logic [EXT_BITS-1:0] sh;
    ext = EXT_BITS'(m);
    if (bl > BL_BITS'(LEN_BITS)) begin
      sh = ext >> (bl - BL_BITS'(LEN_BITS));
    end else begin
      sh = ext << (BL_BITS'(LEN_BITS) - bl);
    end
    return sh[LEN_BITS-1:0];
  endfunction

  logic [2:0][R_BITS-1:0]   m1;
  logic [2:0]               n1;
  logic [R_BITS-1:0]        or1;
  flags_t                   f1;
  logic [2:0][R_BITS-1:0]   m2;
  logic [2:0]               n2;
  logic [BL_BITS-1:0]       bl2;
  flags_t                   f2;
  dir_t                     dir3;
  dir_t                     dir4;
  logic [2:0][2*LEN_BITS-1:0] sq4;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int j = 0; j < 3; j++) begin
        m1[j] <= magnitude(in_data.r[j]);
        n1[j] <= in_data.r[j][R_BITS-1];
      end
      or1      <= magnitude(in_data.r[0]) | magnitude(in_data.r[1]) | magnitude(in_data.r[2]);
      f1.zq    <= in_data.flags.zq;
      f1.zv    <= in_data.flags.zv;
      f1.zr    <= (in_data.r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      m2  <= m1;
      n2  <= n1;
      f2  <= f1;
      bl2 <= bit_length(or1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int j = 0; j < 3; j++) begin
        dir3.mag[j] <= scale(m2[j], bl2);
      end
      dir3.neg   <= n2;
      dir3.flags <= f2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      dir4 <= dir3;
      for (int j = 0; j < 3; j++) begin
        sq4[j] <= (2*LEN_BITS)'(dir3.mag[j]) * (2*LEN_BITS)'(dir3.mag[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      out_data.dir <= dir4;
      out_data.sum <= SQ_BITS'(sq4[0]) + SQ_BITS'(sq4[1]) + SQ_BITS'(sq4[2]);
    end
  end

endmodule
`default_nettype wire

// ===== src/qvr_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qvr_isqrt import qvr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  norm_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output unit_t out_data
);

  localparam int STAGES = ROOT_BITS;

  logic [STAGES-1:0] adv;

  qvr_pipe_ctrl #(.STAGES(STAGES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .adv      (adv)
  );

  logic [SQ_BITS-1:0] rem_q [STAGES];
  logic [SQ_BITS-1:0] res_q [STAGES];
  dir_t               dir_q [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_step
    localparam logic [SQ_BITS-1:0] BIT = SQ_BITS'(1) << (2 * (STAGES - 1 - k));
    logic [SQ_BITS-1:0] rem_in;
    logic [SQ_BITS-1:0] res_in;
    logic [SQ_BITS-1:0] trial;
    dir_t               dir_in;

    if (k == 0) begin : g_first
      assign rem_in = in_data.sum;
      assign res_in = '0;
      assign dir_in = in_data.dir;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
      assign dir_in = dir_q[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + BIT;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
        dir_q[k] <= dir_in;
      end
    end
  end

  assign out_data.dir = dir_q[STAGES-1];
  assign out_data.len = res_q[STAGES-1][ROOT_BITS-1:0];

endmodule
`default_nettype wire

// ===== src/qvr_divide.sv =====
// Three-lane pipelined restoring divider that scales the vector to unit length.
`timescale 1ns / 1ps
`default_nettype none
module qvr_divide import qvr_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  unit_t                       in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] out_x,
  output logic signed [WORD_BITS-1:0] out_y,
  output logic signed [WORD_BITS-1:0] out_z,
  output logic                        zero_quat,
  output logic                        zero_result
);

  localparam int FRAC_BITS = WORD_BITS - 2;
  localparam int STAGES    = FRAC_BITS + 2;
  localparam int REM_BITS  = ROOT_BITS + 1;
  localparam logic [WORD_BITS-1:0] LIM = {1'b0, {(WORD_BITS - 1){1'b1}}};

  typedef logic [WORD_BITS-1:0] quo_t;

  logic [STAGES-1:0] adv;

  qvr_pipe_ctrl #(.STAGES(STAGES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .adv      (adv)
  );

  logic [2:0][WORD_BITS-1:0] quo_q [FRAC_BITS+1];
  logic [2:0][REM_BITS-1:0]  rem_q [FRAC_BITS+1];
  logic [ROOT_BITS-1:0]      den_q [FRAC_BITS+1];
  logic [2:0]                neg_q [FRAC_BITS+1];
  flags_t                    flg_q [FRAC_BITS+1];

  // Integer digit of the quotient; a zero length is treated as one.
  logic [ROOT_BITS-1:0] den0;
  assign den0 = (in_data.len == '0) ? ROOT_BITS'(1) : in_data.len;

  for (genvar j = 0; j < 3; j++) begin : g_first
    logic [REM_BITS-1:0] num;
    logic                ge;
    assign num = REM_BITS'(in_data.dir.mag[j]);
    assign ge  = (num >= REM_BITS'(den0));
    always_ff @(posedge clk) begin
      if (adv[0]) begin
        quo_q[0][j] <= quo_t'(ge);
        rem_q[0][j] <= ge ? num - REM_BITS'(den0) : num;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      den_q[0] <= den0;
      neg_q[0] <= in_data.dir.neg;
      flg_q[0] <= in_data.dir.flags;
    end
  end

  // One fraction bit per stage.
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [REM_BITS-1:0] r2;
      logic                ge;
      assign r2 = {rem_q[k-1][j][REM_BITS-2:0], 1'b0};
      assign ge = (r2 >= REM_BITS'(den_q[k-1]));
      always_ff @(posedge clk) begin
        if (adv[k]) begin
          quo_q[k][j] <= {quo_q[k-1][j][WORD_BITS-2:0], ge};
          rem_q[k][j] <= ge ? r2 - REM_BITS'(den_q[k-1]) : r2;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  function automatic logic [WORD_BITS-1:0] signed_result(input quo_t q, input logic neg,
                                                         input logic kill);
    quo_t m;
    m = (q > LIM) ? LIM : q;
    if (kill) begin
      return '0;
    end
    return neg ? -m : m;
  endfunction

  flags_t fl;
  logic   kill;
  assign fl   = flg_q[FRAC_BITS];
  assign kill = fl.zq || fl.zv || fl.zr;

  always_ff @(posedge clk) begin
    if (adv[STAGES-1]) begin
      out_x       <= signed_result(quo_q[FRAC_BITS][0], neg_q[FRAC_BITS][0], kill);
      out_y       <= signed_result(quo_q[FRAC_BITS][1], neg_q[FRAC_BITS][1], kill);
      out_z       <= signed_result(quo_q[FRAC_BITS][2], neg_q[FRAC_BITS][2], kill);
      zero_quat   <= fl.zq;
      zero_result <= !fl.zq && (fl.zv || fl.zr);
    end
  end

endmodule
`default_nettype wire

// ===== src/quaternion_vector_rotate.sv =====
// Top level of the quaternion vector rotation pipeline, q * v * q^-1 scaled to unit length.
// Pipeline stages from accepted request to result, by segment:
//   3 prescale, 4 rotation, 5 rescale and squared length, 31 square root, WORD_BITS divide.
// One request per cycle unless the output stalls; sqrt and divider retire one bit a stage.
// Reset: synchronous, active high; clears every stage valid bit, payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_vector_rotate import qvr_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input logic       clk,
  input logic       rst,
  qvr_in_if.sink    item,
  qvr_out_if.source result
);

  // The pipeline is a chain of five segments. Each segment tracks its own stage valid
  // bits; a stage loads whenever it is empty or its successor moves, so bubbles
  // collapse and a stalled output only holds back the stages that are actually full.
  // The real part of the vector quaternion adds only a real multiple of |q|^2 to the
  // product and is not used.

  logic    pre_valid, pre_ready;
  scaled_t pre_data;
  logic    rot_valid, rot_ready;
  rot_t    rot_data;
  logic    nrm_valid, nrm_ready;
  norm_t   nrm_data;
  logic    len_valid, len_ready;
  unit_t   len_data;

  // Both quaternions are scaled as blocks so that the largest magnitude has 19 bits,
  // which keeps every product of the rotation exact.
  qvr_prenorm #(.WORD_BITS(WORD_BITS)) u_prenorm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .vec_x    (item.vec_x),
    .vec_y    (item.vec_y),
    .vec_z    (item.vec_z),
    .rot_qx   (item.rot_qx),
    .rot_qy   (item.rot_qy),
    .rot_qz   (item.rot_qz),
    .rot_qw   (item.rot_qw),
    .out_valid(pre_valid),
    .out_ready(pre_ready),
    .out_data (pre_data)
  );

  // The 1/|q|^2 factor of the inverse is positive and drops out of the direction.
  qvr_rotate u_rotate (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pre_valid),
    .in_ready (pre_ready),
    .in_data  (pre_data),
    .out_valid(rot_valid),
    .out_ready(rot_ready),
    .out_data (rot_data)
  );

  qvr_renorm u_renorm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rot_valid),
    .in_ready (rot_ready),
    .in_data  (rot_data),
    .out_valid(nrm_valid),
    .out_ready(nrm_ready),
    .out_data (nrm_data)
  );

  qvr_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (nrm_valid),
    .in_ready (nrm_ready),
    .in_data  (nrm_data),
    .out_valid(len_valid),
    .out_ready(len_ready),
    .out_data (len_data)
  );

  // The last divider stage is the output register of the block.
  qvr_divide #(.WORD_BITS(WORD_BITS)) u_divide (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (len_valid),
    .in_ready   (len_ready),
    .in_data    (len_data),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_x      (result.out_x),
    .out_y      (result.out_y),
    .out_z      (result.out_z),
    .zero_quat  (result.zero_quat),
    .zero_result(result.zero_result)
  );

  // A unit vector always has a component of at least 1/sqrt(3) in magnitude.
  localparam logic signed [WORD_BITS-1:0] HALF = WORD_BITS'(1) << (WORD_BITS - 3);

  logic x_big, y_big, z_big;
  assign x_big = (result.out_x >= HALF) || (result.out_x <= -HALF);
  assign y_big = (result.out_y >= HALF) || (result.out_y <= -HALF);
  assign z_big = (result.out_z >= HALF) || (result.out_z <= -HALF);

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.zero_quat && result.zero_result))
    else $error("both zero flags set on one result");

  a_flagged_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.zero_quat || result.zero_result) |->
      result.out_x == '0 && result.out_y == '0 && result.out_z == '0)
    else $error("flagged result carries a nonzero vector");

  a_unit_length: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.zero_quat && !result.zero_result |-> x_big || y_big || z_big)
    else $error("result is not scaled to unit length");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> item.ready)
    else $error("request refused with an empty output stage");

endmodule
`default_nettype wire
